// ===== rtl/wsmp_pkg.sv =====
// ----------------------------------------------------------------------------
// wsmp_pkg
// shared types and constants for the wav stream to mono pcm block
// ----------------------------------------------------------------------------
package wsmp_pkg;

  localparam logic [1:0] KIND_FORMAT = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_EOS    = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  localparam logic [31:0] TAG_RIFF = 32'h52494646;
  localparam logic [31:0] TAG_WAVE = 32'h57415645;
  localparam logic [31:0] TAG_DATA = 32'h64617461;
  localparam logic [31:0] TAG_FMT  = 32'h666D7420;

  // classified word handed from the parser to the sample stage
  typedef enum logic [1:0] {
    OP_FORMAT = 2'd0,
    OP_DATA   = 2'd1,
    OP_EOS    = 2'd2,
    OP_ERROR  = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  data_byte;
    logic [15:0] format_type;
    logic [15:0] channel_count;
    logic [31:0] rate_hz;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] sample_bits;
    logic [31:0] data_size;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] sample_value;
    logic [15:0] format_type;
    logic [15:0] channel_count;
    logic [31:0] rate_hz;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] sample_bits;
    logic [31:0] data_size;
    logic        last_in_packet;
    logic [10:0] packet_count;
  } res_t;

endpackage

// ===== rtl/wav_stream_to_mono_pcm.sv =====
// ----------------------------------------------------------------------------
// wav_stream_to_mono_pcm
// riff wave byte parser with 16-bit mono sample output framed into packets
// ----------------------------------------------------------------------------
// throughput: one byte word per cycle while the two-entry queue has room to take it
// path: a result word is registered in turn through the stages below
// (parser register, two-entry queue, output register)
// reset: synchronous active-low rst_n clears parser, queue and sample state
module wav_stream_to_mono_pcm #(
  parameter int FRAMES_PER_PACKET = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // data_byte
  input  logic         in_tlast,   // end_of_stream
  output logic         out_tvalid,
  input  logic         out_tready,
  // sample_value, format_type, channel_count, rate_hz, byte_rate,
  // block_align, sample_bits, data_size, packet_count, zero fill
  output logic [191:0] out_tdata,
  output logic         out_tlast,  // last_in_packet
  output logic [1:0]   out_tuser   // result_kind
);
  import wsmp_pkg::*;

  cmd_t p_cmd, q_cmd;
  logic p_valid, p_ready, q_valid, q_ready;
  res_t res;

  wsmp_parser u_parser (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .in_byte(in_tdata), .in_eos(in_tlast),
    .cmd_valid(p_valid), .cmd_ready(p_ready), .cmd(p_cmd)
  );

  wsmp_fifo u_fifo (
    .clk, .rst_n, .wr_valid(p_valid), .wr_ready(p_ready), .wr_data(p_cmd),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
  );

  wsmp_sampler #(.FRAMES_PER_PACKET(FRAMES_PER_PACKET)) u_sampler (
    .clk, .rst_n, .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .res_valid(out_tvalid), .res_ready(out_tready), .res
  );

  assign out_tdata = {5'd0, res.packet_count, res.data_size, res.sample_bits,
                      res.block_align, res.byte_rate, res.rate_hz,
                      res.channel_count, res.format_type, res.sample_value};
  assign out_tlast = res.last_in_packet;
  assign out_tuser = res.result_kind;

endmodule

// ===== rtl/wsmp_parser.sv =====
// ----------------------------------------------------------------------------
// wsmp_parser
// front part: walks the riff chunk structure and classifies each byte
// ----------------------------------------------------------------------------
module wsmp_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic            in_eos,
  output logic            cmd_valid,
  input  logic            cmd_ready,
  output wsmp_pkg::cmd_t  cmd
);
  import wsmp_pkg::*;

  typedef enum logic [2:0] {
    PH_ID, PH_SIZE, PH_FORM, PH_FMT, PH_SKIP, PH_DATA, PH_HALT
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [31:0] len_r, len_nxt;
  logic [63:0] ff0_r, ff0_nxt, ff1_r, ff1_nxt;
  logic        emit;
  cmd_t        cmd_nxt;
  logic [31:0] cnt_inc;
  logic [31:0] len_full;

  assign in_ready = cmd_ready;
  assign cnt_inc  = cnt_r + 32'd1;
  assign len_full = len_r | ({24'd0, in_byte} << {cnt_r[1:0], 3'b000});

  // next state of the chunk walker
  always_comb begin
    phase_nxt = phase_r;
    tag_nxt   = tag_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    ff0_nxt   = ff0_r;
    ff1_nxt   = ff1_r;
    emit      = 1'b0;
    cmd_nxt   = '0;
    cmd_nxt.op        = OP_DATA;
    cmd_nxt.data_byte = in_byte;
    if (in_eos) begin
      emit       = 1'b1;
      cmd_nxt.op = OP_EOS;
      phase_nxt  = PH_ID;
      tag_nxt    = '0;
      cnt_nxt    = '0;
      len_nxt    = '0;
      ff0_nxt    = '0;
      ff1_nxt    = '0;
    end else begin
      unique case (phase_r)
        PH_ID: begin
          tag_nxt = {tag_r[23:0], in_byte};
          cnt_nxt = cnt_inc;
          if (cnt_inc >= 32'd4) begin
            cnt_nxt   = '0;
            len_nxt   = '0;
            phase_nxt = PH_SIZE;
          end
        end
        PH_SIZE: begin
          len_nxt = len_full;
          cnt_nxt = cnt_inc;
          if (cnt_inc >= 32'd4) begin
            cnt_nxt = '0;
            tag_nxt = '0;
            priority if (tag_r == TAG_RIFF) begin
              phase_nxt = PH_FORM;
            end else if (tag_r == TAG_DATA) begin
              phase_nxt             = PH_DATA;
              emit                  = 1'b1;
              cmd_nxt.op            = OP_FORMAT;
              cmd_nxt.format_type   = ff0_r[15:0];
              cmd_nxt.channel_count = ff0_r[31:16];
              cmd_nxt.rate_hz       = ff0_r[63:32];
              cmd_nxt.byte_rate     = ff1_r[31:0];
              cmd_nxt.block_align   = ff1_r[47:32];
              cmd_nxt.sample_bits   = ff1_r[63:48];
              cmd_nxt.data_size     = len_full;
            end else if (tag_r == TAG_FMT) begin
              ff0_nxt   = '0;
              ff1_nxt   = '0;
              phase_nxt = PH_FMT;
            end else begin
              phase_nxt = (len_full == '0) ? PH_ID : PH_SKIP;
            end
          end
        end
        PH_FORM: begin
          tag_nxt = {tag_r[23:0], in_byte};
          cnt_nxt = cnt_inc;
          if (cnt_inc >= 32'd4) begin
            cnt_nxt = '0;
            tag_nxt = '0;
            if ({tag_r[23:0], in_byte} != TAG_WAVE) begin
              phase_nxt  = PH_HALT;
              emit       = 1'b1;
              cmd_nxt.op = OP_ERROR;
            end else begin
              phase_nxt = PH_ID;
            end
          end
        end
        PH_FMT: begin
          if (cnt_r < 32'd16) begin
            if (cnt_r[3]) ff1_nxt = ff1_r | ({56'd0, in_byte} << {cnt_r[2:0], 3'b000});
            else          ff0_nxt = ff0_r | ({56'd0, in_byte} << {cnt_r[2:0], 3'b000});
          end
          cnt_nxt = cnt_inc;
          if (cnt_inc >= 32'd16 && cnt_inc >= len_r) begin
            cnt_nxt   = '0;
            phase_nxt = PH_ID;
          end
        end
        PH_SKIP: begin
          cnt_nxt = cnt_inc;
          if (cnt_inc >= len_r) begin
            cnt_nxt   = '0;
            phase_nxt = PH_ID;
          end
        end
        PH_DATA: emit = 1'b1;
        PH_HALT: ;
        default: ;
      endcase
    end
  end

  // state and registered command word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_ID;
      tag_r     <= '0;
      cnt_r     <= '0;
      len_r     <= '0;
      ff0_r     <= '0;
      ff1_r     <= '0;
      cmd_valid <= 1'b0;
    end else begin
      cmd_valid <= (in_valid && in_ready) ? emit : (cmd_valid && !cmd_ready);
      if (in_valid && in_ready) begin
        phase_r   <= phase_nxt;
        tag_r     <= tag_nxt;
        cnt_r     <= cnt_nxt;
        len_r     <= len_nxt;
        ff0_r     <= ff0_nxt;
        ff1_r     <= ff1_nxt;
        cmd       <= cmd_nxt;
      end
    end
  end

endmodule

// ===== rtl/wsmp_fifo.sv =====
// ----------------------------------------------------------------------------
// wsmp_fifo
// two-entry queue between the parser and the sample stage
// ----------------------------------------------------------------------------
module wsmp_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  wsmp_pkg::cmd_t  wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output wsmp_pkg::cmd_t  rd_data
);
  import wsmp_pkg::*;

  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr_en, rd_en;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  // pointers and fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !wr_en || rd_en) else $error("queue overflow");
  a_fill_track: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && !rd_en |=> cnt_r == $past(cnt_r) + 2'd1) else $error("fill count");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd0 |-> !rd_en) else $error("queue underflow");

endmodule

// ===== rtl/wsmp_sampler.sv =====
// ----------------------------------------------------------------------------
// wsmp_sampler
// back part: forms mono samples, frames packets and drives the result word
// ----------------------------------------------------------------------------
module wsmp_sampler #(
  parameter int FRAMES_PER_PACKET = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  wsmp_pkg::cmd_t  cmd,
  output logic            res_valid,
  input  logic            res_ready,
  output wsmp_pkg::res_t  res
);
  import wsmp_pkg::*;

  localparam int FW = $clog2(FRAMES_PER_PACKET + 1);

  logic [15:0]   bits_r, chans_r;
  logic          half_r, right_r;
  logic [7:0]    low_r;
  logic [15:0]   left_r;
  logic [FW-1:0] frames_r;
  logic          take;
  logic [15:0]   v;
  logic          have_v;
  logic [16:0]   sum;
  logic [16:0]   sum_adj;
  logic [15:0]   avg;
  logic [FW-1:0] frames_inc;
  logic          frames_wrap;
  res_t          res_nxt;
  logic          res_emit;

  assign cmd_ready   = !res_valid || res_ready;
  assign take        = cmd_valid && cmd_ready;
  assign frames_inc  = frames_r + FW'(1);
  assign frames_wrap = 32'(frames_inc) >= 32'(FRAMES_PER_PACKET);
  assign sum         = {left_r[15], left_r} + {v[15], v};
  // truncation toward zero: add one for negative odd sums, then halve
  assign sum_adj     = sum + {16'd0, sum[16] & sum[0]};
  assign avg         = sum_adj[16:1];

  always_comb begin
    if (bits_r == 16'd8) begin
      v      = {cmd.data_byte ^ 8'h80, 8'd0};
      have_v = 1'b1;
    end else begin
      v      = {cmd.data_byte, low_r};
      have_v = half_r;
    end
  end

  // result word for the command being taken
  always_comb begin
    res_nxt  = '0;
    res_emit = 1'b0;
    unique case (cmd.op)
      OP_FORMAT: begin
        res_emit              = 1'b1;
        res_nxt.result_kind   = KIND_FORMAT;
        res_nxt.format_type   = cmd.format_type;
        res_nxt.channel_count = cmd.channel_count;
        res_nxt.rate_hz       = cmd.rate_hz;
        res_nxt.byte_rate     = cmd.byte_rate;
        res_nxt.block_align   = cmd.block_align;
        res_nxt.sample_bits   = cmd.sample_bits;
        res_nxt.data_size     = cmd.data_size;
      end
      OP_DATA: begin
        if (have_v && !(chans_r == 16'd2 && !right_r)) begin
          res_emit               = 1'b1;
          res_nxt.result_kind    = KIND_SAMPLE;
          res_nxt.sample_value   = (chans_r == 16'd2) ? avg : v;
          res_nxt.last_in_packet = frames_wrap;
        end
      end
      OP_EOS: begin
        res_emit             = 1'b1;
        res_nxt.result_kind  = KIND_EOS;
        res_nxt.packet_count = 11'(frames_r);
      end
      OP_ERROR: begin
        res_emit            = 1'b1;
        res_nxt.result_kind = KIND_ERROR;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r    <= '0;
      chans_r   <= '0;
      half_r    <= 1'b0;
      right_r   <= 1'b0;
      low_r     <= '0;
      left_r    <= '0;
      frames_r  <= '0;
      res_valid <= 1'b0;
    end else begin
      res_valid <= take ? res_emit : (res_valid && !res_ready);
      if (take) begin
        res <= res_nxt;
        unique case (cmd.op)
          OP_FORMAT: begin
            bits_r  <= cmd.sample_bits;
            chans_r <= cmd.channel_count;
            half_r  <= 1'b0;
            right_r <= 1'b0;
            low_r   <= '0;
          end
          OP_DATA: begin
            if (bits_r != 16'd8) begin
              half_r <= ~half_r;
              if (!half_r) low_r <= cmd.data_byte;
            end
            if (have_v) begin
              if (chans_r == 16'd2 && !right_r) begin
                left_r  <= v;
                right_r <= 1'b1;
              end else begin
                right_r  <= 1'b0;
                frames_r <= frames_wrap ? '0 : frames_inc;
              end
            end
          end
          OP_EOS: begin
            bits_r   <= '0;
            chans_r  <= '0;
            half_r   <= 1'b0;
            right_r  <= 1'b0;
            low_r    <= '0;
            left_r   <= '0;
            frames_r <= '0;
          end
          OP_ERROR: ;
          default: ;
        endcase
      end
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> res_valid && $stable(res)) else $error("result dropped");
  a_frames: assert property (@(posedge clk) disable iff (!rst_n)
    32'(frames_r) < 32'(FRAMES_PER_PACKET)) else $error("frame count range");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.last_in_packet |-> res.result_kind == KIND_SAMPLE)
    else $error("last outside sample");

endmodule

// ===== dv/wav_stream_to_mono_pcm_tb.sv =====
// ----------------------------------------------------------------------------
// wav_stream_to_mono_pcm_tb
// drives wav byte streams into the parser and checks every result word
// against a behavioural predictor: header parsing, fmt capture, chunk skip,
// riff form errors, 8/16-bit mono and stereo samples, packet framing, flush
// ----------------------------------------------------------------------------
module wav_stream_to_mono_pcm_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wsmp_pkg::*;

  localparam int FPP = 1024;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic [3:0] {
    PH_ID, PH_SIZE, PH_FORM, PH_FMT, PH_SKIP, PH_DATA, PH_HALT
  } phase_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = '0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [191:0] out_tdata;
  logic         out_tlast;
  logic [1:0]   out_tuser;

  wav_stream_to_mono_pcm #(.FRAMES_PER_PACKET(FPP)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  phase_t      pr_phase;
  logic [31:0] pr_tag, pr_cnt, pr_len;
  logic [63:0] pr_fmt0, pr_fmt1;
  logic [7:0]  pr_low;
  logic signed [16:0] pr_left;
  logic        pr_right;
  logic [10:0] pr_frames;

  res_t expected_words[$];
  int   mismatches = 0;
  int   cycles = 0;
  bit   hold_off = 1'b0;
  bit   no_idle = 1'b0;

  task automatic parser_clear();
    pr_phase = PH_ID; pr_tag = '0; pr_cnt = '0; pr_len = '0;
    pr_fmt0 = '0; pr_fmt1 = '0; pr_low = '0;
    pr_left = '0; pr_right = 1'b0; pr_frames = '0;
  endtask

  task automatic push_sample(input logic signed [16:0] v);
    res_t r;
    r = '0;
    r.result_kind = KIND_SAMPLE;
    r.sample_value = v[15:0];
    pr_frames = pr_frames + 11'd1;
    if (pr_frames >= FPP) begin
      r.last_in_packet = 1'b1;
      pr_frames = '0;
    end
    expected_words.push_back(r);
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic eos);
    res_t r;
    logic signed [16:0] v;
    logic [15:0] u;
    r = '0;
    if (eos) begin
      r.result_kind = KIND_EOS;
      r.packet_count = pr_frames;
      parser_clear();
      expected_words.push_back(r);
      return;
    end
    case (pr_phase)
      PH_ID: begin
        pr_tag = {pr_tag[23:0], b};
        pr_cnt++;
        if (pr_cnt >= 4) begin
          pr_cnt = 0; pr_len = 0; pr_phase = PH_SIZE;
        end
      end
      PH_SIZE: begin
        pr_len = pr_len | (32'(b) << (8 * pr_cnt[1:0]));
        pr_cnt++;
        if (pr_cnt >= 4) begin
          pr_cnt = 0;
          if (pr_tag == TAG_RIFF) pr_phase = PH_FORM;
          else if (pr_tag == TAG_DATA) begin
            pr_low = '0; pr_right = 1'b0; pr_phase = PH_DATA;
            r.result_kind = KIND_FORMAT;
            r.format_type = pr_fmt0[15:0];
            r.channel_count = pr_fmt0[31:16];
            r.rate_hz = pr_fmt0[63:32];
            r.byte_rate = pr_fmt1[31:0];
            r.block_align = pr_fmt1[47:32];
            r.sample_bits = pr_fmt1[63:48];
            r.data_size = pr_len;
            expected_words.push_back(r);
          end else if (pr_tag == TAG_FMT) begin
            pr_fmt0 = '0; pr_fmt1 = '0; pr_phase = PH_FMT;
          end else pr_phase = (pr_len == 0) ? PH_ID : PH_SKIP;
          pr_tag = 0;
        end
      end
      PH_FORM: begin
        pr_tag = {pr_tag[23:0], b};
        pr_cnt++;
        if (pr_cnt >= 4) begin
          pr_cnt = 0;
          if (pr_tag != TAG_WAVE) begin
            pr_phase = PH_HALT;
            r.result_kind = KIND_ERROR;
            expected_words.push_back(r);
          end else pr_phase = PH_ID;
          pr_tag = 0;
        end
      end
      PH_FMT: begin
        if (pr_cnt < 16) begin
          if (pr_cnt[3]) pr_fmt1 = pr_fmt1 | (64'(b) << (8 * pr_cnt[2:0]));
          else pr_fmt0 = pr_fmt0 | (64'(b) << (8 * pr_cnt[2:0]));
        end
        pr_cnt++;
        if (pr_cnt >= 16 && pr_cnt >= pr_len) begin
          pr_cnt = 0; pr_phase = PH_ID;
        end
      end
      PH_SKIP: begin
        pr_cnt++;
        if (pr_cnt >= pr_len) begin
          pr_cnt = 0; pr_phase = PH_ID;
        end
      end
      PH_DATA: begin
        if (pr_fmt1[63:48] == 16'd8) v = (17'(b) - 17'sd128) * 17'sd256;
        else if (pr_cnt == 0) begin
          pr_low = b; pr_cnt = 1;
          return;
        end else begin
          pr_cnt = 0;
          u = {b, pr_low};
          v = 17'(signed'(u));
        end
        if (pr_fmt0[31:16] == 16'd2) begin
          if (!pr_right) begin
            pr_left = v; pr_right = 1'b1;
            return;
          end
          pr_right = 1'b0;
          v = 17'((pr_left + v) / 2);
        end
        push_sample(v);
      end
      default: ;
    endcase
  endtask

  // short gaps mostly, now and then a long one
  function automatic int gap_len();
    if (no_idle) return 0;
    if ($urandom_range(99) < 60) return 0;
    if ($urandom_range(99) < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // send one word, predicting on acceptance; valid stays up for a follow-on word
  task automatic send_word(input logic [7:0] b, input logic eos);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= eos;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_byte(b, eos);
    @(negedge clk);
  endtask

  task automatic send_tag(input logic [31:0] t);
    for (int i = 3; i >= 0; i--) send_word(t[8*i +: 8], 1'b0);
  endtask

  task automatic send_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) send_word(v[8*i +: 8], 1'b0);
  endtask

  task automatic send_header(input logic [15:0] fmt, input logic [15:0] ch,
                             input logic [15:0] bits, input int fmt_len,
                             input logic [31:0] dsize);
    send_tag(TAG_RIFF); send_le($urandom, 4); send_tag(TAG_WAVE);
    send_tag(TAG_FMT); send_le(fmt_len, 4);
    send_le(32'(fmt), 2); send_le(32'(ch), 2); send_le($urandom, 4);
    send_le($urandom, 4); send_le($urandom, 2); send_le(32'(bits), 2);
    for (int i = 16; i < fmt_len; i++) send_word(8'($urandom), 1'b0);
    send_tag(TAG_DATA); send_le(dsize, 4);
  endtask

  // receiver side
  always @(negedge clk) begin
    if (hold_off || no_idle) out_tready <= !hold_off;
    else out_tready <= ($urandom_range(99) < 70);
  end

  always @(posedge clk) begin
    res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.result_kind = out_tuser;
      got.last_in_packet = out_tlast;
      {got.packet_count, got.data_size, got.sample_bits, got.block_align,
       got.byte_rate, got.rate_hz, got.channel_count, got.format_type,
       got.sample_value} = out_tdata[186:0];
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", got);
      end else begin
        want = expected_words.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch exp %p got %p", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    send_tag(TAG_RIFF); send_le(0, 4); send_tag(32'h41564557);
    send_word(8'hff, 1'b0); send_word(8'h00, 1'b1);
    // data without fmt, 16-bit mono extremes
    send_tag(TAG_DATA); send_le(32'hffffffff, 4);
    send_le(32'h7fff, 2); send_le(32'h8000, 2); send_word(8'h12, 1'b0);
    send_word(8'h00, 1'b1);
  endtask

  task automatic test_formats();
    send_header(16'd1, 16'd2, 16'd8, 16, 8);
    send_word(8'hff, 1'b0); send_word(8'hff, 1'b0);
    send_word(8'h00, 1'b0); send_word(8'h00, 1'b0);
    send_word(8'h00, 1'b0); send_word(8'hff, 1'b0); send_word(8'h00, 1'b1);
    send_header(16'hffff, 16'd2, 16'd16, 20, 0);
    send_le(32'h8000, 2); send_le(32'h7fff, 2);
    send_le(32'hffff, 2); send_le(32'h0000, 2); send_word(8'h00, 1'b1);
    // short fmt and an unknown chunk including zero size
    send_tag(TAG_RIFF); send_le(0, 4); send_tag(TAG_WAVE);
    send_tag(32'h4c495354); send_le(0, 4);
    send_tag(32'h6a756e6b); send_le(3, 4); send_le(32'h00ffaa, 3);
    send_tag(TAG_FMT); send_le(4, 4);
    for (int i = 0; i < 16; i++) send_word(8'h08, 1'b0);
    send_tag(TAG_DATA); send_le(2, 4); send_le(32'h8080, 2);
    send_word(8'h00, 1'b1);
  endtask

  task automatic test_packet_fill();
    send_header(16'd1, 16'd1, 16'd8, 16, 2048);
    no_idle = 1'b1;
    for (int i = 0; i < FPP + 5; i++) send_word(8'($urandom), 1'b0);
    no_idle = 1'b0;
    send_word(8'h00, 1'b1);
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        send_header(16'd1, 16'd1, 16'd8, 16, 64);
        for (int i = 0; i < 40; i++) send_word(8'($urandom), 1'b0);
      end
    join
    send_word(8'h00, 1'b1);
  endtask

  task automatic test_random();
    int sent, n;
    sent = 0;
    while (sent < 300) begin
      n = $urandom_range(99);
      if (n < 75) begin
        send_header(16'($urandom), $urandom_range(1) ? 16'd2 : 16'($urandom_range(3)),
                    $urandom_range(1) ? 16'd8 : 16'($urandom),
                    $urandom_range(3) == 0 ? $urandom_range(24, 16) : 16, $urandom);
        n = $urandom_range(120, 1);
        for (int i = 0; i < n; i++) send_word(8'($urandom), 1'b0);
        sent += n + 44;
      end else if (n < 88) begin
        send_tag(TAG_RIFF); send_le($urandom, 4);
        send_le($urandom, 4); send_word(8'($urandom), 1'b0);
        sent += 13;
      end else begin
        n = $urandom_range(20, 1);
        for (int i = 0; i < n; i++) send_word(8'($urandom), 1'b0);
        sent += n;
      end
      send_word(8'($urandom), 1'b1);
      sent++;
    end
  endtask

  initial begin
    parser_clear();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_formats();
    test_packet_fill();
    test_backpressure();
    test_random();
    in_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
